/* rtl/dfms_pkg.sv */
// ----------------------------------------------------------------------------
// Flush marker segmenter package
// Shared types, codes and constants of the deflate flush marker segmenter.
// ----------------------------------------------------------------------------
package dfms_pkg;

  // Width of a segment length and of the length limit register.
  localparam int LEN_BITS = 27;
  // Segment counter carries one more bit so that an overrun is visible.
  localparam int CNT_BITS = LEN_BITS + 1;
  // Held byte count: at most four bytes of an empty stored block are held.
  localparam int HELD_BITS = 3;

  // Reset value of the segment length limit.
  localparam logic [LEN_BITS-1:0] MAX_SEGMENT_RESET = LEN_BITS'(66816);
  // A final segment may run this many bytes past the limit.
  localparam logic [CNT_BITS-1:0] FINAL_SLACK = CNT_BITS'(3);

  // Pattern bytes and lengths.
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hff;
  localparam logic [HELD_BITS-1:0] MARKER_LEN = HELD_BITS'(4);
  localparam logic [HELD_BITS-1:0] EMPTY_LEN  = HELD_BITS'(5);
  // Bytes of an empty stored block before its two 0xff bytes.
  localparam logic [HELD_BITS-1:0] EMPTY_ZEROS = HELD_BITS'(3);

  // Configuration register indexes.
  localparam logic [0:0] CFG_IDX_PAIR_MODE   = 1'b0;
  localparam logic [0:0] CFG_IDX_MAX_SEGMENT = 1'b1;

  // Scan phase.
  typedef enum logic {
    PH_SEARCH = 1'b0,
    PH_AFTER  = 1'b1
  } phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CUT      = 2'd0,
    KIND_TOO_LONG = 2'd1,
    KIND_DONE     = 2'd2
  } result_kind_t;

  // Input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_input;
  } item_t;

  // Result word.
  typedef struct packed {
    result_kind_t        result_kind;
    logic [LEN_BITS-1:0] segment_length;
    logic                is_last_segment;
    logic                ends_with_pair;
    logic                last_of_run;
  } result_t;

endpackage

/* rtl/deflate_flush_marker_segmenter.sv */
// ----------------------------------------------------------------------------
// Deflate flush marker segmenter
// Cuts a compressed member body into independently inflatable segments at
// 00 00 FF FF flush markers and the empty stored blocks that follow them.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel takes one body byte per word (or a bare end word). The
//   result channel gives segment cuts, the sticky too-long error and the
//   done word, in order. The cfg channel writes pair_mode (index 0) and
//   max_segment_bytes (index 1); it is always ready. The user must write it
//   only while the block is idle; the block itself does not enforce this.
//   A word is captured in the input register, processed from there, and
//   its results are written to the result queue that feeds the result port.
//   One word is accepted every cycle while the queue has room; a word
//   yields at most two results, so a run of two-result words outpaces the
//   result port and is held off even with a ready receiver. The input
//   register advances only while the queue has room for two results, so a
//   stalled receiver backs up the queue and then holds off the item channel.
//   Reset clears the scan state, the error latch, the queue and the
//   registers (pair_mode 0, max_segment_bytes 66816).
// ----------------------------------------------------------------------------
module deflate_flush_marker_segmenter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  dfms_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output dfms_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [0:0]                      cfg_index,
  input  logic [dfms_pkg::LEN_BITS-1:0]   cfg_data
);

  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // Configuration registers; limit is max_segment_bytes plus the final slack.
  logic                                pair_mode;
  logic [dfms_pkg::LEN_BITS-1:0]       max_seg;
  logic [dfms_pkg::CNT_BITS-1:0]       limit;

  // Input register.
  logic                                s1_valid;
  dfms_pkg::item_t                     s1_item;
  logic                                s1_fire;

  // Scan state; total counts every byte of the open segment, held ones too.
  logic [dfms_pkg::CNT_BITS-1:0]       total;
  logic [dfms_pkg::CNT_BITS-1:0]       total_next;
  logic [dfms_pkg::HELD_BITS-1:0]      held;
  logic [dfms_pkg::HELD_BITS-1:0]      held_next;
  dfms_pkg::phase_t                    phase;
  dfms_pkg::phase_t                    phase_next;
  logic                                empty_seen;
  logic                                empty_next;
  logic                                err;
  logic                                err_next;

  // Per-word working values.
  logic [dfms_pkg::HELD_BITS-1:0]      scan;
  logic [dfms_pkg::CNT_BITS-1:0]       commit_len;
  logic [dfms_pkg::CNT_BITS-1:0]       final_len;
  logic [dfms_pkg::CNT_BITS-1:0]       max_ext;
  logic                                stop;
  dfms_pkg::result_t                   res0;
  dfms_pkg::result_t                   res1;
  logic [1:0]                          nres;

  // Result queue.
  dfms_pkg::result_t                   q_mem [QDEPTH];
  logic [QPTR_BITS-1:0]                wr_ptr;
  logic [QPTR_BITS-1:0]                rd_ptr;
  logic [QCNT_BITS-1:0]                q_count;
  logic                                pop;

  // Next marker prefix length after one byte while searching.
  function automatic logic [dfms_pkg::HELD_BITS-1:0] search_next(
    input logic [dfms_pkg::HELD_BITS-1:0] c,
    input logic [7:0]                     b
  );
    logic [dfms_pkg::HELD_BITS-1:0] n;
    n = '0;
    case (c)
      3'd0: n = (b == dfms_pkg::BYTE_ZERO) ? 3'd1 : 3'd0;
      3'd1: n = (b == dfms_pkg::BYTE_ZERO) ? 3'd2 : 3'd0;
      3'd2: begin
        if (b == dfms_pkg::BYTE_ONES) n = 3'd3;
        else if (b == dfms_pkg::BYTE_ZERO) n = 3'd2;
        else n = 3'd0;
      end
      3'd3: begin
        if (b == dfms_pkg::BYTE_ONES) n = dfms_pkg::MARKER_LEN;
        else if (b == dfms_pkg::BYTE_ZERO) n = 3'd1;
        else n = 3'd0;
      end
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Marker prefix left after rescanning a failed empty block test: the held
  // part of the empty block followed by the byte that broke it.
  function automatic logic [dfms_pkg::HELD_BITS-1:0] rescan(
    input logic [dfms_pkg::HELD_BITS-1:0] h,
    input logic [7:0]                     b
  );
    logic [dfms_pkg::HELD_BITS-1:0] n;
    n = '0;
    case (h)
      3'd2:    n = (b == dfms_pkg::BYTE_ONES) ? 3'd3 : 3'd0;
      3'd3:    n = (b == dfms_pkg::BYTE_ZERO) ? 3'd2 : 3'd0;
      3'd4:    n = (b == dfms_pkg::BYTE_ZERO) ? 3'd1 : 3'd0;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic dfms_pkg::result_t make_res(
    input dfms_pkg::result_kind_t           kind,
    input logic [dfms_pkg::CNT_BITS-1:0]    len,
    input logic                             last_seg,
    input logic                             pair
  );
    dfms_pkg::result_t r;
    r.result_kind     = kind;
    r.segment_length  = len[dfms_pkg::LEN_BITS-1:0];
    r.is_last_segment = last_seg;
    r.ends_with_pair  = pair;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_mode <= 1'b0;
      max_seg   <= dfms_pkg::MAX_SEGMENT_RESET;
      limit     <= {1'b0, dfms_pkg::MAX_SEGMENT_RESET} + dfms_pkg::FINAL_SLACK;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dfms_pkg::CFG_IDX_PAIR_MODE: pair_mode <= cfg_data[0];
        dfms_pkg::CFG_IDX_MAX_SEGMENT: begin
          max_seg <= cfg_data;
          limit   <= {1'b0, cfg_data} + dfms_pkg::FINAL_SLACK;
        end
        default: pair_mode <= pair_mode;
      endcase
    end
  end

  // Input register; it moves on while the queue has room for two results.
  assign s1_fire    = s1_valid && (q_count <= QCNT_BITS'(QDEPTH - 2));
  assign item_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  assign max_ext = {1'b0, max_seg};

  // Scan one word: marker search, empty block test, cuts and end of input.
  always_comb begin
    total_next = total;
    held_next  = held;
    phase_next = phase;
    empty_next = empty_seen;
    err_next   = err;
    scan       = '0;
    commit_len = '0;
    final_len  = '0;
    stop       = 1'b0;
    res0       = '0;
    res1       = '0;
    nres       = 2'd0;
    if (s1_fire) begin
      if (err) begin
        // A latched error answers every non-bare word with one error.
        if (s1_item.byte_valid || s1_item.end_of_input) begin
          res0 = make_res(dfms_pkg::KIND_TOO_LONG, '0, 1'b0, 1'b0);
          nres = 2'd1;
        end
      end else begin
        if (s1_item.byte_valid) begin
          if (phase == dfms_pkg::PH_SEARCH) begin
            // Track the longest marker prefix that ends at this byte.
            scan       = search_next(held, s1_item.data_byte);
            total_next = total + 1'b1;
            if (scan == dfms_pkg::MARKER_LEN) begin
              held_next  = '0;
              phase_next = dfms_pkg::PH_AFTER;
              empty_next = 1'b0;
            end else begin
              held_next = scan;
            end
          end else if (s1_item.data_byte == ((held < dfms_pkg::EMPTY_ZEROS) ?
                                             dfms_pkg::BYTE_ZERO :
                                             dfms_pkg::BYTE_ONES)) begin
            // Byte continues an empty stored block.
            total_next = total + 1'b1;
            if (held == dfms_pkg::EMPTY_LEN - 1'b1) begin
              held_next  = '0;
              empty_next = 1'b1;
            end else begin
              held_next = held + 1'b1;
            end
          end else begin
            // Empty block test failed: settle the marker, rescan held bytes.
            commit_len = total - {{(dfms_pkg::CNT_BITS-dfms_pkg::HELD_BITS){1'b0}}, held};
            if (!(pair_mode && !empty_seen)) begin
              if (commit_len > max_ext) begin
                res0     = make_res(dfms_pkg::KIND_TOO_LONG, '0, 1'b0, 1'b0);
                nres     = 2'd1;
                err_next = 1'b1;
                stop     = 1'b1;
              end else begin
                res0       = make_res(dfms_pkg::KIND_CUT, commit_len, 1'b0, empty_seen);
                nres       = 2'd1;
                total_next = {{(dfms_pkg::CNT_BITS-dfms_pkg::HELD_BITS){1'b0}}, held}
                             + 1'b1;
              end
            end else begin
              total_next = total + 1'b1;
            end
            empty_next = 1'b0;
            phase_next = dfms_pkg::PH_SEARCH;
            held_next  = rescan(held, s1_item.data_byte);
          end
        end
        if (!stop) begin
          if (!s1_item.end_of_input) begin
            // Length check on an open segment.
            if (total_next[dfms_pkg::CNT_BITS-1] ||
                (phase_next == dfms_pkg::PH_SEARCH && total_next > limit)) begin
              if (nres == 2'd0) res0 = make_res(dfms_pkg::KIND_TOO_LONG, '0, 1'b0, 1'b0);
              else res1 = make_res(dfms_pkg::KIND_TOO_LONG, '0, 1'b0, 1'b0);
              nres     = nres + 2'd1;
              err_next = 1'b1;
            end
          end else begin
            // End of input: settle a pending marker, then cut the rest.
            final_len = total_next;
            if (phase_next == dfms_pkg::PH_AFTER) begin
              commit_len = total_next
                           - {{(dfms_pkg::CNT_BITS-dfms_pkg::HELD_BITS){1'b0}}, held_next};
              if (!(pair_mode && !empty_next)) begin
                if (commit_len > max_ext || commit_len[dfms_pkg::CNT_BITS-1]) begin
                  if (nres == 2'd0) res0 = make_res(dfms_pkg::KIND_TOO_LONG, '0, 1'b0, 1'b0);
                  else res1 = make_res(dfms_pkg::KIND_TOO_LONG, '0, 1'b0, 1'b0);
                  nres     = nres + 2'd1;
                  err_next = 1'b1;
                  stop     = 1'b1;
                end else begin
                  if (nres == 2'd0) begin
                    res0 = make_res(dfms_pkg::KIND_CUT, commit_len, 1'b0, empty_next);
                  end else begin
                    res1 = make_res(dfms_pkg::KIND_CUT, commit_len, 1'b0, empty_next);
                  end
                  nres      = nres + 2'd1;
                  final_len = {{(dfms_pkg::CNT_BITS-dfms_pkg::HELD_BITS){1'b0}}, held_next};
                end
              end
            end
            if (!stop) begin
              if (final_len > limit || final_len[dfms_pkg::CNT_BITS-1]) begin
                if (nres == 2'd0) res0 = make_res(dfms_pkg::KIND_TOO_LONG, '0, 1'b0, 1'b0);
                else res1 = make_res(dfms_pkg::KIND_TOO_LONG, '0, 1'b0, 1'b0);
                err_next = 1'b1;
              end else if (final_len == '0) begin
                if (nres == 2'd0) res0 = make_res(dfms_pkg::KIND_DONE, '0, 1'b0, 1'b0);
                else res1 = make_res(dfms_pkg::KIND_DONE, '0, 1'b0, 1'b0);
              end else begin
                if (nres == 2'd0) res0 = make_res(dfms_pkg::KIND_CUT, final_len, 1'b1, 1'b0);
                else res1 = make_res(dfms_pkg::KIND_CUT, final_len, 1'b1, 1'b0);
              end
              nres       = nres + 2'd1;
              total_next = '0;
              held_next  = '0;
              phase_next = dfms_pkg::PH_SEARCH;
              empty_next = 1'b0;
            end
          end
        end
      end
      // Mark the final result of this word.
      if (nres == 2'd1) res0.last_of_run = 1'b1;
      if (nres == 2'd2) res1.last_of_run = 1'b1;
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      held       <= '0;
      phase      <= dfms_pkg::PH_SEARCH;
      empty_seen <= 1'b0;
      err        <= 1'b0;
    end else begin
      total      <= total_next;
      held       <= held_next;
      phase      <= phase_next;
      empty_seen <= empty_next;
      err        <= err_next;
    end
  end

  // Result queue: up to two words in, one word out per cycle while the receiver is ready.
  assign pop          = result_valid && result_ready;
  assign result_valid = (q_count != '0);
  assign result       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (nres != 2'd0) begin
      q_mem[wr_ptr] <= res0;
    end
    if (nres == 2'd2) begin
      q_mem[wr_ptr + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPTR_BITS'(nres);
      rd_ptr  <= rd_ptr + QPTR_BITS'(pop);
      q_count <= q_count + QCNT_BITS'(nres) - QCNT_BITS'(pop);
    end
  end

endmodule

/* rtl/dfms_checker.sv */
// ----------------------------------------------------------------------------
// Flush marker segmenter checker
// Port-level assertions on the segmenter, attached by a bind statement.
// ----------------------------------------------------------------------------
module dfms_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input dfms_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input dfms_pkg::result_t result
);

  // Set once an error word has been delivered.
  logic err_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (result_valid && result_ready &&
                 result.result_kind == dfms_pkg::KIND_TOO_LONG) begin
      err_seen <= 1'b1;
    end
  end

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // The error is sticky: nothing but errors follows it.
  a_sticky_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && err_seen |-> result.result_kind == dfms_pkg::KIND_TOO_LONG)
    else $error("non-error result after an error");

  // A final segment closes the run of its input word.
  a_final_closes_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_last_segment |->
      result.last_of_run && result.result_kind == dfms_pkg::KIND_CUT)
    else $error("final segment not last of run");

  // A stalled result word holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // A stalled input word holds.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("input word changed while stalled");

endmodule

bind deflate_flush_marker_segmenter dfms_checker u_dfms_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
